@@ design/positional_list_table_core_macros.svh @@
// Assertion macros shared by the checker of the positional list table.
// Needs nothing else; include by bare file name.
`ifndef POSITIONAL_LIST_TABLE_CORE_MACROS_SVH
`define POSITIONAL_LIST_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/plt_pkg.sv @@
// Package of the positional list table: operation and status codes,
// stream field layout and the default list depth. Depends on nothing.
`default_nettype none

package plt_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int ST_W    = 3;
    localparam int COUNT_W = 7;

    // Request word: op, position, data_value, zero padded to 48 bits.
    localparam int S_TDATA_W = 48;
    // Result word: status, found_position, entry_value, entry_count, padded to 56 bits.
    localparam int M_TDATA_W = 56;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

@@ design/plt_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used for the entry store of the positional list table.
`default_nettype none

module plt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/positional_list_table_core.sv @@
// Top level of the positional list table: request decode, the shift, search
// and dump sequencer, and the result register. Depends on plt_pkg and plt_ram.
//
// Requests enter on the s_ channel with an operation (clear, insert, delete,
// search, update, dump), a 1-based position and a signed 32-bit value. Results
// leave on the m_ channel: one per request with m_tlast high, or for a dump of
// a non-empty list one per entry in list order with m_tlast on the final one.
// The entries live in one RAM with a registered read; insert and
// delete move the tail one entry per cycle, search and dump read one per cycle.
// Clear, a refused operation and a delete of the final entry go straight to
// the result; update and an insert at the end write the entry first; any other
// insert shifts the tail up and then writes, any other delete shifts the tail
// down, and a search reads entries in order up to the first match or the end.
// The block takes one request at a time and is ready for the next one in the
// same cycle as the last result of the one before appears; s_tready is high
// only while it is idle, even when a result still waits in the output register.
// Reset clears the entry count and the handshake state only; the RAM is not
// cleared, and no entry is read before it was written. When the receiver
// stalls, the output register holds its result and a dump pauses its reads.
`default_nettype none

module positional_list_table_core
    import plt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata, from bit 0 up: op[2:0], position[9:3], data_value[41:10], zero pad.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata, from bit 0 up: status[2:0], found_position[9:3],
    // entry_value[41:10], entry_count[48:42], zero pad.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // Comparison width: wide enough for a position, the count and count + 1.
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_DUMP   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    // Request fields.
    logic [OP_W-1:0]   in_op;
    logic [POS_W-1:0]  in_position;
    logic [DATA_W-1:0] in_data_value;

    assign in_op         = s_tdata[OP_W-1:0];
    assign in_position   = s_tdata[OP_W+POS_W-1:OP_W];
    assign in_data_value = s_tdata[OP_W+POS_W+DATA_W-1:OP_W+POS_W];

    // Control state.
    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              issue_done_reg, issue_done_next;
    logic              pending_reg, pending_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Request context and walk pointers.
    logic [OP_W-1:0]   op_reg, op_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [ADDR_W-1:0] pos_idx_reg, pos_idx_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;   // next RAM read address
    logic [ADDR_W-1:0] src_reg, src_next;     // address of the word in rd_data

    // Pending single result.
    logic [ST_W-1:0]   res_status_reg, res_status_next;
    logic [POS_W-1:0]  res_pos_reg, res_pos_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;

    // Output register.
    logic [ST_W-1:0]    m_status_reg, m_status_next;
    logic [POS_W-1:0]   m_pos_reg, m_pos_next;
    logic [DATA_W-1:0]  m_value_reg, m_value_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic               m_tlast_reg, m_tlast_next;

    // RAM port signals.
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [DATA_W-1:0] ram_rd_data;

    plt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    // Derived values used by the decode and the walks.
    logic [CMP_W-1:0]  pos_w, cnt_w, cnt_plus_w, src_pos_w;
    logic [ADDR_W-1:0] pos_idx_in, pos_addr_in, last_idx;
    logic              is_full, is_empty, out_free, accept, shift_up, hit;

    assign pos_w       = CMP_W'(in_position);
    assign cnt_w       = CMP_W'(count_reg);
    assign cnt_plus_w  = cnt_w + CMP_W'(1);
    assign src_pos_w   = CMP_W'(src_reg) + CMP_W'(1);
    assign pos_idx_in  = ADDR_W'(pos_w - CMP_W'(1));
    assign pos_addr_in = ADDR_W'(pos_w);
    assign last_idx    = ADDR_W'(cnt_w - CMP_W'(1));
    assign is_full     = (cnt_w == CMP_W'(DEPTH));
    assign is_empty    = (count_reg == '0);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign shift_up    = (op_reg == OP_INSERT);
    assign hit         = pending_reg && (ram_rd_data == value_reg);

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_done_next = issue_done_reg;
        pending_next    = pending_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        pos_idx_next    = pos_idx_reg;
        addr_next       = addr_reg;
        src_next        = src_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_value_next  = res_value_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_pos_next      = m_pos_reg;
        m_value_next    = m_value_reg;
        m_count_next    = m_count_reg;
        m_tlast_next    = m_tlast_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = shift_up ? (src_reg + ADDR_W'(1)) : (src_reg - ADDR_W'(1));
        ram_wr_data     = ram_rd_data;
        ram_rd_en       = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next         = in_op;
                    value_next      = in_data_value;
                    pos_idx_next    = pos_idx_in;
                    issue_done_next = 1'b0;
                    pending_next    = 1'b0;
                    res_status_next = ST_OK;
                    res_pos_next    = '0;
                    res_value_next  = '0;
                    state_next      = S_FINISH;
                    unique case (in_op)
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_INSERT: begin
                            // The full check wins over the position check.
                            if (is_full) begin
                                res_status_next = ST_FULL;
                            end else if (pos_w == '0 || pos_w > cnt_plus_w) begin
                                res_status_next = ST_BADPOS;
                            end else if (pos_w == cnt_plus_w) begin
                                state_next = S_WRITE;
                            end else begin
                                addr_next  = last_idx;
                                state_next = S_SHIFT;
                            end
                        end
                        OP_DELETE, OP_UPDATE: begin
                            if (is_empty) begin
                                res_status_next = ST_EMPTY;
                            end else if (pos_w == '0 || pos_w > cnt_w) begin
                                res_status_next = ST_BADPOS;
                            end else if (in_op == OP_UPDATE) begin
                                state_next = S_WRITE;
                            end else if (pos_w == cnt_w) begin
                                count_next = count_reg - CNT_W'(1);
                            end else begin
                                addr_next  = pos_addr_in;
                                state_next = S_SHIFT;
                            end
                        end
                        OP_SEARCH: begin
                            if (is_empty) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                addr_next  = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        OP_DUMP: begin
                            if (is_empty) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                addr_next  = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                            res_status_next = ST_BADPOS;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // Read one entry per cycle and write it back one slot over in
                // the next cycle; insert walks down from the tail, delete up.
                if (!issue_done_reg) begin
                    ram_rd_en    = 1'b1;
                    src_next     = addr_reg;
                    pending_next = 1'b1;
                    if (addr_reg == (shift_up ? pos_idx_reg : last_idx)) begin
                        issue_done_next = 1'b1;
                    end else if (shift_up) begin
                        addr_next = addr_reg - ADDR_W'(1);
                    end else begin
                        addr_next = addr_reg + ADDR_W'(1);
                    end
                end else begin
                    pending_next = 1'b0;
                end
                if (pending_reg) begin
                    ram_wr_en = 1'b1;
                end
                if (issue_done_reg) begin
                    if (shift_up) begin
                        state_next = S_WRITE;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_FINISH;
                    end
                end
            end

            S_WRITE: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_idx_reg;
                ram_wr_data = value_reg;
                if (op_reg == OP_INSERT) begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_FINISH;
            end

            S_SEARCH: begin
                if (!issue_done_reg) begin
                    ram_rd_en    = 1'b1;
                    src_next     = addr_reg;
                    pending_next = 1'b1;
                    if (addr_reg == last_idx) begin
                        issue_done_next = 1'b1;
                    end else begin
                        addr_next = addr_reg + ADDR_W'(1);
                    end
                end else begin
                    pending_next = 1'b0;
                end
                if (hit) begin
                    res_status_next = ST_OK;
                    res_pos_next    = src_pos_w[POS_W-1:0];
                    res_value_next  = ram_rd_data;
                    state_next      = S_FINISH;
                end else if (pending_reg && issue_done_reg) begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_FINISH;
                end
            end

            S_DUMP: begin
                // A new read may start when the word in rd_data is empty or
                // moves into the output register in this cycle.
                if (!issue_done_reg && (!pending_reg || out_free)) begin
                    ram_rd_en    = 1'b1;
                    src_next     = addr_reg;
                    pending_next = 1'b1;
                    if (addr_reg == last_idx) begin
                        issue_done_next = 1'b1;
                    end else begin
                        addr_next = addr_reg + ADDR_W'(1);
                    end
                end else if (pending_reg && out_free) begin
                    pending_next = 1'b0;
                end
                if (pending_reg && out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = ST_OK;
                    m_pos_next    = src_pos_w[POS_W-1:0];
                    m_value_next  = ram_rd_data;
                    m_count_next  = cnt_w[COUNT_W-1:0];
                    m_tlast_next  = (src_reg == last_idx);
                    if (src_reg == last_idx) begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_pos_next    = res_pos_reg;
                    m_value_next  = res_value_reg;
                    m_count_next  = cnt_w[COUNT_W-1:0];
                    m_tlast_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            issue_done_reg <= 1'b0;
            pending_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_done_reg <= issue_done_next;
            pending_reg    <= pending_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        pos_idx_reg    <= pos_idx_next;
        addr_reg       <= addr_next;
        src_reg        <= src_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_pos_reg      <= m_pos_next;
        m_value_reg    <= m_value_next;
        m_count_reg    <= m_count_next;
        m_tlast_reg    <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {
        (M_TDATA_W - ST_W - POS_W - DATA_W - COUNT_W)'(0),
        m_count_reg, m_value_reg, m_pos_reg, m_status_reg
    };

endmodule

`default_nettype wire

@@ design/plt_checker.sv @@
// Port-level checker of the positional list table, bound to the top level.
// Depends on plt_pkg and positional_list_table_core_macros.svh.
`default_nettype none
`include "positional_list_table_core_macros.svh"

module plt_checker
    import plt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    logic [ST_W-1:0] status;

    assign status = m_tdata[ST_W-1:0];

    `PLT_ASSERT_NXT(a_valid_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `PLT_ASSERT_NXT(a_data_holds, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    `PLT_ASSERT_IMP(a_status_legal, aclk, aresetn, m_tvalid, status <= ST_NOTFOUND, "status code out of range")
    `PLT_ASSERT_IMP(a_run_is_dump, aclk, aresetn, m_tvalid && !m_tlast, status == ST_OK && m_tdata[9:3] != '0, "non-final result is not a dumped entry")
    `PLT_ASSERT_IMP(a_fail_zero, aclk, aresetn, m_tvalid && status != ST_OK, m_tdata[41:3] == '0, "failed request carries position or value")

endmodule

bind positional_list_table_core plt_checker u_plt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ bench/positional_list_table_core_tb.sv @@
// Self-checking testbench for positional_list_table_core: directed and random requests,
// with a shadow copy of the list that predicts every result.
// Depends on plt_pkg and the design files only.
`timescale 1ns / 1ps

module positional_list_table_core_tb;
    import plt_pkg::*;

    // Op codes 6 and 7 are not defined by the package; the block must refuse them.
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;
    localparam int RANDOM_REQUESTS = 420;
    // Longest stretch without any handshake in a correct run is roughly a long
    // sender gap plus a full walk of the list plus a long receiver stall.
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } list_request_t;

    typedef struct {
        logic [ST_W-1:0]    status;
        logic [POS_W-1:0]   position;
        logic [DATA_W-1:0]  value;
        logic [COUNT_W-1:0] count;
        logic               last;
    } list_result_t;

    typedef enum {MIX_PHASE, FILL_PHASE, DRAIN_PHASE} load_mode_t;

    // Shadow of the list contents and the results the block still owes us.
    class list_mirror;
        logic [DATA_W-1:0] entries[LIST_DEPTH];
        int                total;
        list_result_t      pending_results[$];
        int                mismatches;

        function new();
            total = 0;
            mismatches = 0;
        endfunction

        function void add_result(logic [ST_W-1:0] status, int position,
                                 logic [DATA_W-1:0] value, bit last);
            list_result_t r;
            r.status   = status;
            r.position = position[POS_W-1:0];
            r.value    = value;
            r.count    = total[COUNT_W-1:0];
            r.last     = last;
            pending_results.push_back(r);
        endfunction

        // Applies one accepted request to the shadow list and queues its results.
        function void note_request(list_request_t req);
            int p;
            int hit;
            p = req.position;
            hit = -1;
            case (req.op)
                OP_CLEAR: begin
                    total = 0;
                    add_result(ST_OK, 0, '0, 1'b1);
                end
                OP_INSERT: begin
                    // The full check wins over a bad position.
                    if (total >= LIST_DEPTH) begin
                        add_result(ST_FULL, 0, '0, 1'b1);
                    end else if (p < 1 || p > total + 1) begin
                        add_result(ST_BADPOS, 0, '0, 1'b1);
                    end else begin
                        for (int i = total; i >= p; i--) entries[i] = entries[i-1];
                        entries[p-1] = req.value;
                        total++;
                        add_result(ST_OK, 0, '0, 1'b1);
                    end
                end
                OP_DELETE, OP_UPDATE: begin
                    // The empty check wins over a bad position.
                    if (total == 0) begin
                        add_result(ST_EMPTY, 0, '0, 1'b1);
                    end else if (p < 1 || p > total) begin
                        add_result(ST_BADPOS, 0, '0, 1'b1);
                    end else begin
                        if (req.op == OP_UPDATE) begin
                            entries[p-1] = req.value;
                        end else begin
                            for (int i = p - 1; i + 1 < total; i++)
                                entries[i] = entries[i+1];
                            total--;
                        end
                        add_result(ST_OK, 0, '0, 1'b1);
                    end
                end
                OP_SEARCH: begin
                    if (total == 0) begin
                        add_result(ST_EMPTY, 0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < total; i++)
                            if (hit < 0 && entries[i] == req.value) hit = i;
                        if (hit >= 0) add_result(ST_OK, hit + 1, entries[hit], 1'b1);
                        else add_result(ST_NOTFOUND, 0, '0, 1'b1);
                    end
                end
                OP_DUMP: begin
                    if (total == 0) begin
                        add_result(ST_EMPTY, 0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < total; i++)
                            add_result(ST_OK, i + 1, entries[i], (i + 1 == total));
                    end
                end
                default: add_result(ST_BADPOS, 0, '0, 1'b1);
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compares one accepted result with the oldest outstanding prediction.
        task check_result(logic [M_TDATA_W-1:0] word, logic tlast);
            list_result_t want;
            logic [ST_W-1:0]    got_status;
            logic [POS_W-1:0]   got_position;
            logic [DATA_W-1:0]  got_value;
            logic [COUNT_W-1:0] got_count;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %h", word));
                return;
            end
            want = pending_results.pop_front();
            got_status   = word[0 +: ST_W];
            got_position = word[ST_W +: POS_W];
            got_value    = word[ST_W + POS_W +: DATA_W];
            got_count    = word[ST_W + POS_W + DATA_W +: COUNT_W];
            if (got_status !== want.status)
                report_mismatch($sformatf("status %0d, predicted %0d",
                                          got_status, want.status));
            if (got_position !== want.position)
                report_mismatch($sformatf("found_position %0d, predicted %0d",
                                          got_position, want.position));
            if (got_value !== want.value)
                report_mismatch($sformatf("entry_value %0d, predicted %0d",
                                          $signed(got_value), $signed(want.value)));
            if (got_count !== want.count)
                report_mismatch($sformatf("entry_count %0d, predicted %0d",
                                          got_count, want.count));
            if (tlast !== want.last)
                report_mismatch($sformatf("tlast %0b, predicted %0b", tlast, want.last));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    list_mirror shadow = new();

    // Steady flags switch off the random gaps for a whole phase, so that some
    // stretches run back to back on each side.
    bit source_steady;
    bit sink_steady;
    int idle_cycles;

    positional_list_table_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A position inside 1..limit, or inside 1..3 when limit is below 1.
    function automatic logic [POS_W-1:0] valid_slot(int limit);
        if (limit < 1) return POS_W'($urandom_range(1, 3));
        return POS_W'($urandom_range(1, limit));
    endfunction

    // A position outside 1..limit: zero, the field maximum, or anything above limit.
    function automatic logic [POS_W-1:0] bad_slot(int limit);
        int r;
        r = $urandom_range(0, 2);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return POS_W'($urandom_range(limit + 1, (1 << POS_W) - 1));
    endfunction

    // Values lean towards a small set so that duplicates make the first-match
    // rule of the search matter, with the signed extremes mixed in.
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return DATA_W'($urandom_range(0, 7));
        if (r < 35) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom();
    endfunction

    // Half of the searches on a non-empty list take a value that is in the list.
    function automatic logic [DATA_W-1:0] search_value();
        if (shadow.total > 0 && $urandom_range(0, 1) == 1)
            return shadow.entries[$urandom_range(0, shadow.total - 1)];
        return pick_value();
    endfunction

    function automatic list_request_t make_request(logic [OP_W-1:0] op,
                                                   logic [POS_W-1:0] position,
                                                   logic [DATA_W-1:0] value);
        list_request_t req;
        req.op = op;
        req.position = position;
        req.value = value;
        return req;
    endfunction

    // Draws one random request; the mode sets how strongly the list grows or shrinks.
    function automatic list_request_t random_request(load_mode_t mode);
        int n;
        int r;
        int ins_valid;
        int ins_bad;
        int del_valid;
        int del_bad;
        int srch;
        int upd;
        int dmp;
        int clr;
        n = shadow.total;
        r = $urandom_range(0, 99);
        case (mode)
            FILL_PHASE: begin
                ins_valid = 78; ins_bad = 83; del_valid = 85; del_bad = 86;
                srch = 91; upd = 95; dmp = 98; clr = 98;
            end
            DRAIN_PHASE: begin
                ins_valid = 8; ins_bad = 10; del_valid = 68; del_bad = 74;
                srch = 82; upd = 90; dmp = 95; clr = 96;
            end
            default: begin
                ins_valid = 24; ins_bad = 28; del_valid = 44; del_bad = 48;
                srch = 68; upd = 82; dmp = 90; clr = 95;
            end
        endcase
        if (r < ins_valid) return make_request(OP_INSERT, valid_slot(n + 1), pick_value());
        if (r < ins_bad)   return make_request(OP_INSERT, bad_slot(n + 1), pick_value());
        if (r < del_valid) return make_request(OP_DELETE, valid_slot(n), pick_value());
        if (r < del_bad)   return make_request(OP_DELETE, bad_slot(n), pick_value());
        if (r < srch)      return make_request(OP_SEARCH, POS_W'($urandom()), search_value());
        if (r < upd) begin
            if ($urandom_range(0, 5) == 0)
                return make_request(OP_UPDATE, bad_slot(n), pick_value());
            return make_request(OP_UPDATE, valid_slot(n), pick_value());
        end
        if (r < dmp) return make_request(OP_DUMP, POS_W'($urandom()), $urandom());
        if (r < clr) return make_request(OP_CLEAR, POS_W'($urandom()), $urandom());
        if ($urandom_range(0, 1) == 1)
            return make_request(OP_SPARE_6, POS_W'($urandom()), $urandom());
        return make_request(OP_SPARE_7, POS_W'($urandom()), $urandom());
    endfunction

    // Presents one request from a falling edge, holds it until the block takes
    // it, and returns at the falling edge after the handshake with s_tvalid
    // still high, so that a following request keeps the valid line up.
    task automatic send_request(list_request_t req);
        s_tdata = '0;
        s_tdata[0 +: OP_W] = req.op;
        s_tdata[OP_W +: POS_W] = req.position;
        s_tdata[OP_W + POS_W +: DATA_W] = req.value;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        shadow.note_request(req);
        @(negedge aclk);
    endtask

    // Idles the request side for a random number of cycles unless the phase runs steady.
    task automatic source_pause();
        int gap;
        gap = source_steady ? 0 : gap_length();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_with_pause(list_request_t req);
        send_request(req);
        source_pause();
    endtask

    // The receiver drops m_tready for random stretches, decided at falling edges.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_steady) begin
                m_tready = 1'b1;
                stall_left = 0;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = gap_length();
            end
        end
    end

    // Results are sampled at the rising edge, where the values driven at the
    // previous falling edge and the block's registered outputs are both stable.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            shadow.check_result(m_tdata, m_tlast);
    end

    // Ends the run if neither channel moves anything for too long.
    always @(posedge aclk) begin
        if (aresetn !== 1'b1) begin
            idle_cycles <= 0;
        end else if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
                     (m_tvalid === 1'b1 && m_tready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        load_mode_t mode;
        int sent;
        int phase_len;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        source_steady = 1'b0;
        sink_steady = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part: every operation but clear on an empty list, the position limits
        // of insert, delete and update, signed extremes, first and last slots,
        // a search hit and a miss, both unused op codes, and dumps.
        send_with_pause(make_request(OP_DUMP,   7'd0,   32'h0));
        send_with_pause(make_request(OP_SEARCH, 7'd0,   32'h0));
        send_with_pause(make_request(OP_DELETE, 7'd1,   32'h0));
        send_with_pause(make_request(OP_UPDATE, 7'd1,   32'h1));
        send_with_pause(make_request(OP_INSERT, 7'd0,   32'h1));
        send_with_pause(make_request(OP_INSERT, 7'd2,   32'h1));
        send_with_pause(make_request(OP_INSERT, 7'd1,   32'h8000_0000));
        send_with_pause(make_request(OP_INSERT, 7'd2,   32'h7FFF_FFFF));
        send_with_pause(make_request(OP_INSERT, 7'd1,   32'hFFFF_FFFF));
        send_with_pause(make_request(OP_INSERT, 7'd2,   32'h0));
        send_with_pause(make_request(OP_INSERT, 7'd127, 32'h5));
        send_with_pause(make_request(OP_SEARCH, 7'd0,   32'h7FFF_FFFF));
        send_with_pause(make_request(OP_SEARCH, 7'd127, 32'h0001_2345));
        send_with_pause(make_request(OP_UPDATE, 7'd127, 32'h1));
        send_with_pause(make_request(OP_UPDATE, 7'd0,   32'h1));
        send_with_pause(make_request(OP_UPDATE, 7'd4,   32'hAAAA_AAAA));
        send_with_pause(make_request(OP_DELETE, 7'd0,   32'h0));
        send_with_pause(make_request(OP_DELETE, 7'd5,   32'h0));
        send_with_pause(make_request(OP_DELETE, 7'd2,   32'h0));
        send_with_pause(make_request(OP_DUMP,   7'd127, 32'hFFFF_FFFF));
        send_with_pause(make_request(OP_SPARE_6, 7'd1,  32'h1));
        send_with_pause(make_request(OP_SPARE_7, 7'd127, 32'hFFFF_FFFF));
        send_with_pause(make_request(OP_DELETE, 7'd3,   32'h0));
        send_with_pause(make_request(OP_CLEAR,  7'd127, 32'hFFFF_FFFF));
        send_with_pause(make_request(OP_DUMP,   7'd0,   32'h0));

        // Random part in phases. The first phase leans on inserts to fill the list
        // towards full; later phases grow, shrink or mix at random.
        sent = 0;
        mode = FILL_PHASE;
        while (sent < RANDOM_REQUESTS) begin
            source_steady = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            if (mode == FILL_PHASE)
                phase_len = (LIST_DEPTH - shadow.total) * 4 / 3 + 8;
            else
                phase_len = $urandom_range(20, 50);
            for (int k = 0; k < phase_len && sent < RANDOM_REQUESTS; k++) begin
                send_with_pause(random_request(mode));
                sent++;
            end
            case ($urandom_range(0, 2))
                0: mode = FILL_PHASE;
                1: mode = DRAIN_PHASE;
                default: mode = MIX_PHASE;
            endcase
        end
        s_tvalid = 1'b0;

        // Wait for every predicted result, then give the block a full list walk
        // more to show any result it should not produce.
        while (shadow.pending_results.size() != 0) @(posedge aclk);
        repeat (LIST_DEPTH + 8) @(posedge aclk);
        if (shadow.pending_results.size() != 0)
            shadow.report_mismatch($sformatf("%0d results never arrived",
                                             shadow.pending_results.size()));

        if (shadow.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
